FILE: design/status_led_pattern_sequencer_core_defines.svh
// Assertion macros for the status LED pattern sequencer checker.
// Depends on nothing; included by files that assert.
`ifndef STATUS_LED_PATTERN_SEQUENCER_CORE_DEFINES_SVH
`define STATUS_LED_PATTERN_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SLPS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define SLPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/slps_pkg.sv
// Shared types and constants for the status LED pattern sequencer.
// Depends on nothing; used by the core and its checker.
package slps_pkg;

	localparam int COLOR_W    = 8;
	localparam int TICKS_W    = 16;
	localparam int PHASE_W    = 3;
	localparam int OP_W       = 3;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [OP_W-1:0] OP_TICK        = 3'd0;
	localparam logic [OP_W-1:0] OP_SET_COLOR   = 3'd1;
	localparam logic [OP_W-1:0] OP_START_BOOT  = 3'd2;
	localparam logic [OP_W-1:0] OP_WAIT_ON     = 3'd3;
	localparam logic [OP_W-1:0] OP_WAIT_OFF    = 3'd4;
	localparam logic [OP_W-1:0] OP_SYNC_OK     = 3'd5;
	localparam logic [OP_W-1:0] OP_CANCEL_BOOT = 3'd6;
	localparam logic [OP_W-1:0] OP_CANCEL_SYNC = 3'd7;

	localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOOT_STEP    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_PULSE   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WAITING_STEP = 8'd3;

	localparam logic [PHASE_W-1:0] PHASE_RED   = 3'd0;
	localparam logic [PHASE_W-1:0] PHASE_GREEN = 3'd1;
	localparam logic [PHASE_W-1:0] PHASE_BLUE  = 3'd2;

	localparam logic [COLOR_W-1:0] BRIGHTNESS_RST   = 8'd64;
	localparam logic [TICKS_W-1:0] BOOT_STEP_RST    = 16'd250;
	localparam logic [TICKS_W-1:0] SYNC_PULSE_RST   = 16'd200;
	localparam logic [TICKS_W-1:0] WAITING_STEP_RST = 16'd500;
	localparam logic [TICKS_W-1:0] ELAPSED_MAX      = {TICKS_W{1'b1}};

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [COLOR_W-1:0] red_in;
		logic [COLOR_W-1:0] green_in;
		logic [COLOR_W-1:0] blue_in;
	} cmd_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red_out;
		logic [COLOR_W-1:0] green_out;
		logic [COLOR_W-1:0] blue_out;
	} led_t;

endpackage

FILE: design/status_led_pattern_sequencer_core.sv
// Status LED pattern sequencer: command register, pattern state and LED result register.
// Depends on slps_pkg.
//
// Takes one command or millisecond-tick transaction per clock and writes at most one colour
// per transaction to the LED channel, passing through the command register and then the
// result register. The rate is set by the single command register feeding it; a stall
// on the LED channel holds the command register and stalls the command channel in the same
// cycle. Configuration writes are always ready and take effect on the next transaction.
module status_led_pattern_sequencer_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	output logic                            cmd_stall,
	input  slps_pkg::cmd_t                  cmd,
	output logic                            led_valid,
	input  logic                            led_stall,
	output slps_pkg::led_t                  led,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [slps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [slps_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic [slps_pkg::COLOR_W-1:0] brightness_q;
	logic [slps_pkg::TICKS_W-1:0] boot_step_q, sync_pulse_q, waiting_step_q;

	logic                         boot_running_q, boot_first_q;
	logic [slps_pkg::PHASE_W-1:0] boot_phase_q;
	logic [slps_pkg::TICKS_W-1:0] boot_elapsed_q;
	logic                         sync_running_q;
	logic [slps_pkg::TICKS_W-1:0] sync_elapsed_q;
	logic                         wait_running_q, wait_lit_q, wait_first_q;
	logic [slps_pkg::TICKS_W-1:0] wait_elapsed_q;

	logic                         boot_running_d, boot_first_d;
	logic [slps_pkg::PHASE_W-1:0] boot_phase_d;
	logic [slps_pkg::TICKS_W-1:0] boot_elapsed_d;
	logic                         sync_running_d;
	logic [slps_pkg::TICKS_W-1:0] sync_elapsed_d;
	logic                         wait_running_d, wait_lit_d, wait_first_d;
	logic [slps_pkg::TICKS_W-1:0] wait_elapsed_d;

	logic [slps_pkg::TICKS_W-1:0] boot_inc, sync_inc, wait_inc;

	logic           valid_s1;
	slps_pkg::cmd_t cmd_s1;
	logic           led_valid_q;
	slps_pkg::led_t led_q;

	logic           out_free, go, emit;
	slps_pkg::led_t res;

	assign out_free  = !led_valid_q || !led_stall;
	assign go        = valid_s1 && out_free;
	assign cmd_stall = valid_s1 && !out_free;
	assign cfg_ready = 1'b1;
	assign led_valid = led_valid_q;
	assign led       = led_q;

	assign boot_inc = (boot_elapsed_q == slps_pkg::ELAPSED_MAX) ? slps_pkg::ELAPSED_MAX
		: boot_elapsed_q + 1'b1;
	assign sync_inc = (sync_elapsed_q == slps_pkg::ELAPSED_MAX) ? slps_pkg::ELAPSED_MAX
		: sync_elapsed_q + 1'b1;
	assign wait_inc = (wait_elapsed_q == slps_pkg::ELAPSED_MAX) ? slps_pkg::ELAPSED_MAX
		: wait_elapsed_q + 1'b1;

	always_comb begin
		boot_running_d = boot_running_q;
		boot_first_d   = boot_first_q;
		boot_phase_d   = boot_phase_q;
		boot_elapsed_d = boot_elapsed_q;
		sync_running_d = sync_running_q;
		sync_elapsed_d = sync_elapsed_q;
		wait_running_d = wait_running_q;
		wait_lit_d     = wait_lit_q;
		wait_first_d   = wait_first_q;
		wait_elapsed_d = wait_elapsed_q;
		emit           = 1'b0;
		res            = '0;
		unique case (cmd_s1.operation)
			slps_pkg::OP_TICK: begin
				boot_elapsed_d = boot_inc;
				sync_elapsed_d = sync_inc;
				wait_elapsed_d = wait_inc;
				priority if (sync_running_q) begin
					if (sync_inc >= sync_pulse_q) begin
						sync_running_d = 1'b0;
						emit           = 1'b1;
					end
				end else if (boot_running_q) begin
					if (boot_first_q || boot_inc >= boot_step_q) begin
						boot_first_d   = 1'b0;
						boot_elapsed_d = '0;
						boot_phase_d   = boot_phase_q + 1'b1;
						emit           = 1'b1;
						unique case (boot_phase_q)
							slps_pkg::PHASE_RED:   res.red_out   = brightness_q;
							slps_pkg::PHASE_GREEN: res.green_out = brightness_q;
							slps_pkg::PHASE_BLUE:  res.blue_out  = brightness_q;
							default:               boot_running_d = 1'b0;
						endcase
					end
				end else if (wait_running_q) begin
					if (wait_first_q || wait_inc >= waiting_step_q) begin
						wait_first_d   = 1'b0;
						wait_elapsed_d = '0;
						wait_lit_d     = !wait_lit_q;
						emit           = 1'b1;
						if (!wait_lit_q) begin
							res.red_out   = brightness_q;
							res.green_out = brightness_q >> 2;
						end
					end
				end
			end
			slps_pkg::OP_SET_COLOR: begin
				boot_running_d = 1'b0;
				sync_running_d = 1'b0;
				wait_running_d = 1'b0;
				wait_lit_d     = 1'b0;
				wait_first_d   = 1'b1;
				wait_elapsed_d = '0;
				emit           = 1'b1;
				res.red_out    = cmd_s1.red_in;
				res.green_out  = cmd_s1.green_in;
				res.blue_out   = cmd_s1.blue_in;
			end
			slps_pkg::OP_START_BOOT: begin
				boot_running_d = 1'b1;
				boot_phase_d   = slps_pkg::PHASE_RED;
				boot_first_d   = 1'b1;
				boot_elapsed_d = '0;
			end
			slps_pkg::OP_WAIT_ON: begin
				if (!wait_running_q) begin
					wait_running_d = 1'b1;
					wait_lit_d     = 1'b0;
					wait_first_d   = 1'b1;
					wait_elapsed_d = '0;
				end
			end
			slps_pkg::OP_WAIT_OFF: begin
				wait_running_d = 1'b0;
				wait_lit_d     = 1'b0;
				wait_first_d   = 1'b1;
				wait_elapsed_d = '0;
			end
			slps_pkg::OP_SYNC_OK: begin
				boot_running_d = 1'b0;
				wait_running_d = 1'b0;
				wait_lit_d     = 1'b0;
				wait_first_d   = 1'b1;
				wait_elapsed_d = '0;
				sync_running_d = 1'b1;
				sync_elapsed_d = '0;
				emit           = 1'b1;
				res.green_out  = brightness_q;
			end
			slps_pkg::OP_CANCEL_BOOT: boot_running_d = 1'b0;
			slps_pkg::OP_CANCEL_SYNC: sync_running_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q   <= slps_pkg::BRIGHTNESS_RST;
			boot_step_q    <= slps_pkg::BOOT_STEP_RST;
			sync_pulse_q   <= slps_pkg::SYNC_PULSE_RST;
			waiting_step_q <= slps_pkg::WAITING_STEP_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				slps_pkg::REG_BRIGHTNESS:   brightness_q   <= cfg_data[slps_pkg::COLOR_W-1:0];
				slps_pkg::REG_BOOT_STEP:    boot_step_q    <= cfg_data[slps_pkg::TICKS_W-1:0];
				slps_pkg::REG_SYNC_PULSE:   sync_pulse_q   <= cfg_data[slps_pkg::TICKS_W-1:0];
				slps_pkg::REG_WAITING_STEP: waiting_step_q <= cfg_data[slps_pkg::TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_running_q <= 1'b0;
			boot_first_q   <= 1'b1;
			boot_phase_q   <= '0;
			boot_elapsed_q <= '0;
			sync_running_q <= 1'b0;
			sync_elapsed_q <= '0;
			wait_running_q <= 1'b0;
			wait_lit_q     <= 1'b0;
			wait_first_q   <= 1'b1;
			wait_elapsed_q <= '0;
		end else if (go) begin
			boot_running_q <= boot_running_d;
			boot_first_q   <= boot_first_d;
			boot_phase_q   <= boot_phase_d;
			boot_elapsed_q <= boot_elapsed_d;
			sync_running_q <= sync_running_d;
			sync_elapsed_q <= sync_elapsed_d;
			wait_running_q <= wait_running_d;
			wait_lit_q     <= wait_lit_d;
			wait_first_q   <= wait_first_d;
			wait_elapsed_q <= wait_elapsed_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			led_valid_q <= 1'b0;
		end else begin
			if (!cmd_stall) begin
				valid_s1 <= cmd_valid;
			end
			if (out_free) begin
				led_valid_q <= go && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd_stall && cmd_valid) begin
			cmd_s1 <= cmd;
		end
		if (go && emit) begin
			led_q <= res;
		end
	end

endmodule

FILE: design/slps_checker.sv
// Port-level checker for the status LED pattern sequencer, bound to the core.
// Depends on slps_pkg and status_led_pattern_sequencer_core_defines.svh.
`include "status_led_pattern_sequencer_core_defines.svh"

module slps_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            cmd_valid,
	input logic                            cmd_stall,
	input slps_pkg::cmd_t                  cmd,
	input logic                            led_valid,
	input logic                            led_stall,
	input slps_pkg::led_t                  led,
	input logic                            cfg_valid,
	input logic                            cfg_ready
);

	logic set_accept;
	logic led_free;

	assign set_accept = cmd_valid && !cmd_stall && cmd.operation == slps_pkg::OP_SET_COLOR;
	assign led_free   = !led_valid || !led_stall;

	`SLPS_ASSERT_NEXT(a_led_hold, clk, arst_n, led_valid && led_stall,
		led_valid && $stable(led), "stalled LED transaction changed")

	`SLPS_ASSERT_SAME(a_stall_cause, clk, arst_n, cmd_stall,
		led_valid && led_stall, "command stalled while LED channel was free")

	`SLPS_ASSERT_SAME(a_set_color, clk, arst_n, $past(set_accept, 2) && $past(led_free, 1),
		led_valid && led.red_out == $past(cmd.red_in, 2)
		&& led.green_out == $past(cmd.green_in, 2)
		&& led.blue_out == $past(cmd.blue_in, 2), "set colour not written to LED")

	`SLPS_ASSERT_SAME(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready,
		"configuration write not taken")

endmodule

bind status_led_pattern_sequencer_core slps_checker u_slps_checker (.*);
